### hdl/emap_pkg.sv
package emap_pkg;

	localparam int CH_W        = 2;
	localparam int SAMPLE_W    = 12;
	localparam int PULSE_W     = 15;
	localparam int ANGLE_W     = 8;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 15;

	localparam int JOINTS_DEF       = 4;
	localparam int SMOOTH_SHIFT_DEF = 3;

	localparam logic [ANGLE_W-1:0]  ANGLE_FULL = 8'd180;

	localparam logic [SAMPLE_W-1:0] WIN_LOW_RST   = 12'd600;
	localparam logic [SAMPLE_W-1:0] WIN_HIGH_RST  = 12'd3500;
	localparam logic [PULSE_W-1:0]  PULSE_MIN_RST = 15'd650;
	localparam logic [PULSE_W-1:0]  PULSE_MAX_RST = 15'd2350;

	// Both divisions produce a quotient of known width, so the divider runs a fixed
	// number of restoring steps.
	localparam int DIV_W   = SAMPLE_W + PULSE_W;
	localparam int Q_PULSE = PULSE_W;
	localparam int Q_ANGLE = ANGLE_W;
	localparam int CNT_W   = $clog2(Q_PULSE + 1);

	localparam int STEP_W = 3;
	localparam logic [STEP_W-1:0] STEP_WAIT   = 3'd0;
	localparam logic [STEP_W-1:0] STEP_AVG    = 3'd1;
	localparam logic [STEP_W-1:0] STEP_MUL_P  = 3'd2;
	localparam logic [STEP_W-1:0] STEP_DIV_P  = 3'd3;
	localparam logic [STEP_W-1:0] STEP_PULSE  = 3'd4;
	localparam logic [STEP_W-1:0] STEP_MUL_A  = 3'd5;
	localparam logic [STEP_W-1:0] STEP_DIV_A  = 3'd6;
	localparam logic [STEP_W-1:0] STEP_FINISH = 3'd7;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIN_LOW   = 2'd0,
		REG_WIN_HIGH  = 2'd1,
		REG_PULSE_MIN = 2'd2,
		REG_PULSE_MAX = 2'd3
	} emap_reg_e_t;

	typedef enum logic [2:0] {
		OP_NOP    = 3'd0,
		OP_LOAD   = 3'd1,
		OP_AVG    = 3'd2,
		OP_MUL_P  = 3'd3,
		OP_DIV    = 3'd4,
		OP_PULSE  = 3'd5,
		OP_MUL_A  = 3'd6,
		OP_FINISH = 3'd7
	} emap_op_t;

	typedef enum logic [2:0] {
		JC_NONE     = 3'd0,
		JC_ALWAYS   = 3'd1,
		JC_NO_IN    = 3'd2,
		JC_CNT      = 3'd3,
		JC_OUT_BUSY = 3'd4
	} emap_jc_t;

	typedef struct packed {
		emap_op_t            op;
		emap_jc_t            jc;
		logic [STEP_W-1:0]   target;
		logic                in_rdy;
		logic                out_ld;
	} emap_cw_t;

	typedef struct packed {
		logic cnt_more;
	} emap_stat_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] win_low;
		logic [SAMPLE_W-1:0] win_high;
		logic [PULSE_W-1:0]  pulse_min;
		logic [PULSE_W-1:0]  pulse_max;
	} emap_cfg_t;

	typedef struct packed {
		logic [CH_W-1:0]     joint;
		logic [SAMPLE_W-1:0] level;
		logic [PULSE_W-1:0]  pulse;
		logic [ANGLE_W-1:0]  angle;
	} emap_res_t;

	// Control store: a jump is taken to target when its condition holds,
	// otherwise the sequencer falls through to the next step.
	function automatic emap_cw_t emap_program(input logic [STEP_W-1:0] step);
		emap_cw_t cw;
		case (step)
			STEP_WAIT:   cw = '{op: OP_LOAD,   jc: JC_NO_IN,    target: STEP_WAIT,
			                    in_rdy: 1'b1, out_ld: 1'b0};
			STEP_AVG:    cw = '{op: OP_AVG,    jc: JC_NONE,     target: STEP_WAIT,
			                    in_rdy: 1'b0, out_ld: 1'b0};
			STEP_MUL_P:  cw = '{op: OP_MUL_P,  jc: JC_NONE,     target: STEP_WAIT,
			                    in_rdy: 1'b0, out_ld: 1'b0};
			STEP_DIV_P:  cw = '{op: OP_DIV,    jc: JC_CNT,      target: STEP_DIV_P,
			                    in_rdy: 1'b0, out_ld: 1'b0};
			STEP_PULSE:  cw = '{op: OP_PULSE,  jc: JC_NONE,     target: STEP_WAIT,
			                    in_rdy: 1'b0, out_ld: 1'b0};
			STEP_MUL_A:  cw = '{op: OP_MUL_A,  jc: JC_NONE,     target: STEP_WAIT,
			                    in_rdy: 1'b0, out_ld: 1'b0};
			STEP_DIV_A:  cw = '{op: OP_DIV,    jc: JC_CNT,      target: STEP_DIV_A,
			                    in_rdy: 1'b0, out_ld: 1'b0};
			STEP_FINISH: cw = '{op: OP_FINISH, jc: JC_OUT_BUSY, target: STEP_FINISH,
			                    in_rdy: 1'b0, out_ld: 1'b1};
			default:     cw = '{op: OP_NOP,    jc: JC_ALWAYS,   target: STEP_WAIT,
			                    in_rdy: 1'b0, out_ld: 1'b0};
		endcase
		return cw;
	endfunction

endpackage

### hdl/emap_ifs.sv
interface emap_in_if;
	logic                             valid;
	logic                             ready;
	logic [emap_pkg::CH_W-1:0]        joint_channel;
	logic [emap_pkg::SAMPLE_W-1:0]    adc_sample;

	modport source (output valid, joint_channel, adc_sample, input ready);
	modport sink (input valid, joint_channel, adc_sample, output ready);
endinterface

interface emap_out_if;
	logic                             valid;
	logic                             ready;
	logic [emap_pkg::CH_W-1:0]        joint_out;
	logic [emap_pkg::SAMPLE_W-1:0]    smoothed_level;
	logic [emap_pkg::PULSE_W-1:0]     pulse_width_us;
	logic [emap_pkg::ANGLE_W-1:0]     angle_degrees;

	modport source (output valid, joint_out, smoothed_level, pulse_width_us, angle_degrees,
		input ready);
	modport sink (input valid, joint_out, smoothed_level, pulse_width_us, angle_degrees,
		output ready);
endinterface

interface emap_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [emap_pkg::CFG_IDX_W-1:0]   index;
	logic [emap_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### hdl/emap_datapath.sv
module emap_datapath #(
	parameter int JOINTS       = emap_pkg::JOINTS_DEF,
	parameter int SMOOTH_SHIFT = emap_pkg::SMOOTH_SHIFT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  emap_pkg::emap_cw_t             cw,
	input  logic                           in_xfer,
	input  logic [emap_pkg::CH_W-1:0]      joint_channel,
	input  logic [emap_pkg::SAMPLE_W-1:0]  adc_sample,
	input  emap_pkg::emap_cfg_t            cfg,
	output emap_pkg::emap_stat_t           stat,
	output emap_pkg::emap_res_t            res
);

	localparam int JW    = (JOINTS > 1) ? $clog2(JOINTS) : 1;
	localparam int SUM_W = emap_pkg::SAMPLE_W + SMOOTH_SHIFT + 1;
	localparam logic [4:0] JOINTS_V = 5'(JOINTS);

	logic [emap_pkg::CH_W-1:0]     ch_q;
	logic [emap_pkg::SAMPLE_W-1:0] smp_q;
	logic [JW-1:0]                 slot_q;
	logic [emap_pkg::SAMPLE_W-1:0] avg_q;
	logic [emap_pkg::SAMPLE_W-1:0] store_q [JOINTS];
	logic [emap_pkg::DIV_W-1:0]    rem_q;
	logic [emap_pkg::DIV_W-1:0]    dsh_q;
	logic [emap_pkg::PULSE_W-1:0]  quo_q;
	logic [emap_pkg::CNT_W-1:0]    cnt_q;
	logic [emap_pkg::PULSE_W-1:0]  pulse_q;
	logic                          dir_q;
	logic                          empty_q;

	logic [4:0]                    slot_full;
	logic [JW-1:0]                 slot;
	logic [SUM_W-1:0]              old_x;
	logic [SUM_W-1:0]              sum;
	logic [emap_pkg::SAMPLE_W-1:0] avg_new;
	logic [emap_pkg::SAMPLE_W-1:0] lvl_clamp;
	logic [emap_pkg::SAMPLE_W-1:0] lvl_diff;
	logic [emap_pkg::SAMPLE_W-1:0] win_span;
	logic [emap_pkg::PULSE_W-1:0]  pulse_span;
	logic [emap_pkg::PULSE_W-1:0]  pls_clamp;
	logic [emap_pkg::PULSE_W-1:0]  pls_diff;
	logic [emap_pkg::PULSE_W-1:0]  pls_den;
	logic                          rem_ge;
	logic [emap_pkg::ANGLE_W-1:0]  angle_next;

	// The channel is at most 3, so three conditional subtractions reduce it modulo JOINTS.
	always_comb begin
		slot_full = 5'(joint_channel);
		for (int i = 0; i < 3; i++) begin
			if (slot_full >= JOINTS_V) begin
				slot_full = slot_full - JOINTS_V;
			end
		end
		slot = slot_full[JW-1:0];
	end

	always_comb begin
		old_x   = SUM_W'(store_q[slot_q]);
		sum     = (old_x << SMOOTH_SHIFT) - old_x + SUM_W'(smp_q);
		avg_new = sum[SMOOTH_SHIFT +: emap_pkg::SAMPLE_W];
	end

	always_comb begin
		if (avg_q < cfg.win_low) begin
			lvl_clamp = cfg.win_low;
		end else if (avg_q > cfg.win_high) begin
			lvl_clamp = cfg.win_high;
		end else begin
			lvl_clamp = avg_q;
		end
		lvl_diff   = lvl_clamp - cfg.win_low;
		win_span   = cfg.win_high - cfg.win_low;
		pulse_span = (cfg.pulse_max > cfg.pulse_min) ? cfg.pulse_max - cfg.pulse_min
		                                             : cfg.pulse_min - cfg.pulse_max;
		if (pulse_q < cfg.pulse_min) begin
			pls_clamp = cfg.pulse_min;
		end else if (pulse_q > cfg.pulse_max) begin
			pls_clamp = cfg.pulse_max;
		end else begin
			pls_clamp = pulse_q;
		end
		pls_diff = pls_clamp - cfg.pulse_min;
		pls_den  = cfg.pulse_max - cfg.pulse_min;
		rem_ge   = rem_q >= dsh_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < JOINTS; i++) begin
				store_q[i] <= '0;
			end
		end else if (cw.op == emap_pkg::OP_AVG) begin
			store_q[slot_q] <= avg_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			case (cw.op)
				emap_pkg::OP_MUL_P: cnt_q <= emap_pkg::CNT_W'(emap_pkg::Q_PULSE);
				emap_pkg::OP_MUL_A: cnt_q <= emap_pkg::CNT_W'(emap_pkg::Q_ANGLE);
				emap_pkg::OP_DIV:   cnt_q <= cnt_q - 1'b1;
				default:            cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cw.op)
			emap_pkg::OP_LOAD: begin
				if (in_xfer) begin
					ch_q   <= joint_channel;
					smp_q  <= adc_sample;
					slot_q <= slot;
				end
			end
			emap_pkg::OP_AVG: begin
				avg_q <= avg_new;
			end
			emap_pkg::OP_MUL_P: begin
				rem_q   <= emap_pkg::DIV_W'(lvl_diff) * emap_pkg::DIV_W'(pulse_span);
				dsh_q   <= emap_pkg::DIV_W'(win_span) << (emap_pkg::Q_PULSE - 1);
				quo_q   <= '0;
				dir_q   <= cfg.pulse_max > cfg.pulse_min;
				empty_q <= cfg.win_high <= cfg.win_low;
			end
			emap_pkg::OP_DIV: begin
				if (rem_ge) begin
					rem_q <= rem_q - dsh_q;
				end
				quo_q <= {quo_q[emap_pkg::PULSE_W-2:0], rem_ge};
				dsh_q <= dsh_q >> 1;
			end
			emap_pkg::OP_PULSE: begin
				if (empty_q) begin
					pulse_q <= cfg.pulse_max;
				end else if (dir_q) begin
					pulse_q <= cfg.pulse_max - quo_q;
				end else begin
					pulse_q <= cfg.pulse_max + quo_q;
				end
			end
			emap_pkg::OP_MUL_A: begin
				rem_q   <= emap_pkg::DIV_W'(pls_diff) * emap_pkg::DIV_W'(emap_pkg::ANGLE_FULL);
				dsh_q   <= emap_pkg::DIV_W'(pls_den) << (emap_pkg::Q_ANGLE - 1);
				quo_q   <= '0;
				empty_q <= cfg.pulse_max <= cfg.pulse_min;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		if (empty_q) begin
			angle_next = '0;
		end else if (quo_q > emap_pkg::PULSE_W'(emap_pkg::ANGLE_FULL)) begin
			angle_next = emap_pkg::ANGLE_FULL;
		end else begin
			angle_next = quo_q[emap_pkg::ANGLE_W-1:0];
		end
	end

	assign stat.cnt_more = cnt_q != emap_pkg::CNT_W'(1);
	assign res.joint     = ch_q;
	assign res.level     = avg_q;
	assign res.pulse     = pulse_q;
	assign res.angle     = angle_next;

endmodule

### hdl/ema_to_servo_pulse_mapper.sv
// Smoothed joint sensor to servo pulse mapper.
// The samples channel carries a joint channel and a 12-bit converter sample; each
// transfer updates that joint's moving average (old*7 + sample)/8 and yields one
// item on the results channel: the joint, the new average, the servo pulse width
// in microseconds and the servo angle from 0 to 180 degrees.
// The cfg channel writes the converter window and the pulse limits by register
// index; it is always ready and should be used only while no item is in flight.
// A microcoded sequencer steps a small datapath; the two linear maps share one
// restoring divider that settles one quotient bit per cycle.
// Each sample runs through 15 divider steps for the pulse, 8 for the angle and six
// control steps around them; the next sample is taken only after the last one has
// been loaded into the output register.
// The result sits in an output register, so the next sample is accepted while it
// waits. If the receiver has not taken it by the next result, the sequencer holds in
// its last step until the output register is free.
// Reset clears the averages to zero, loads the register defaults and empties the
// output register.
module ema_to_servo_pulse_mapper #(
	parameter int JOINTS       = emap_pkg::JOINTS_DEF,
	parameter int SMOOTH_SHIFT = emap_pkg::SMOOTH_SHIFT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	emap_in_if.sink     samples,
	emap_out_if.source  results,
	emap_cfg_if.sink    cfg
);

	logic [emap_pkg::STEP_W-1:0] pc_q;
	logic [emap_pkg::STEP_W-1:0] pc_d;
	emap_pkg::emap_cw_t          cw;
	emap_pkg::emap_stat_t        stat;
	emap_pkg::emap_res_t         res;
	emap_pkg::emap_cfg_t         cfg_q;
	logic                        in_xfer;
	logic                        out_free;
	logic                        out_load;
	logic                        take;
	logic                        out_valid_q;
	emap_pkg::emap_res_t         out_q;

	always_comb begin
		cw       = emap_pkg::emap_program(pc_q);
		in_xfer  = samples.valid && cw.in_rdy;
		out_free = !out_valid_q || results.ready;
		out_load = cw.out_ld && out_free;
		case (cw.jc)
			emap_pkg::JC_NONE:     take = 1'b0;
			emap_pkg::JC_ALWAYS:   take = 1'b1;
			emap_pkg::JC_NO_IN:    take = !in_xfer;
			emap_pkg::JC_CNT:      take = stat.cnt_more;
			emap_pkg::JC_OUT_BUSY: take = !out_free;
			default:               take = 1'b0;
		endcase
		pc_d = take ? cw.target : pc_q + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= emap_pkg::STEP_WAIT;
		end else begin
			pc_q <= pc_d;
		end
	end

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.win_low   <= emap_pkg::WIN_LOW_RST;
			cfg_q.win_high  <= emap_pkg::WIN_HIGH_RST;
			cfg_q.pulse_min <= emap_pkg::PULSE_MIN_RST;
			cfg_q.pulse_max <= emap_pkg::PULSE_MAX_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				emap_pkg::REG_WIN_LOW:   cfg_q.win_low   <= cfg.data[emap_pkg::SAMPLE_W-1:0];
				emap_pkg::REG_WIN_HIGH:  cfg_q.win_high  <= cfg.data[emap_pkg::SAMPLE_W-1:0];
				emap_pkg::REG_PULSE_MIN: cfg_q.pulse_min <= cfg.data[emap_pkg::PULSE_W-1:0];
				emap_pkg::REG_PULSE_MAX: cfg_q.pulse_max <= cfg.data[emap_pkg::PULSE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	emap_datapath #(
		.JOINTS       (JOINTS),
		.SMOOTH_SHIFT (SMOOTH_SHIFT)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cw            (cw),
		.in_xfer       (in_xfer),
		.joint_channel (samples.joint_channel),
		.adc_sample    (samples.adc_sample),
		.cfg           (cfg_q),
		.stat          (stat),
		.res           (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= res;
		end
	end

	assign samples.ready          = cw.in_rdy;
	assign results.valid          = out_valid_q;
	assign results.joint_out      = out_q.joint;
	assign results.smoothed_level = out_q.level;
	assign results.pulse_width_us = out_q.pulse;
	assign results.angle_degrees  = out_q.angle;

	a_start_leaves_wait: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> pc_q == emap_pkg::STEP_AVG)
		else $error("sequencer did not advance after a sample transfer");

	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(results.valid) |-> $past(pc_q) == emap_pkg::STEP_FINISH)
		else $error("result appeared outside the final step");

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> results.angle_degrees <= emap_pkg::ANGLE_FULL)
		else $error("angle above full scale");

	a_pulse_range: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && (cfg_q.win_high > cfg_q.win_low)
			&& (cfg_q.pulse_max > cfg_q.pulse_min)
		|-> (results.pulse_width_us >= cfg_q.pulse_min)
			&& (results.pulse_width_us <= cfg_q.pulse_max))
		else $error("pulse outside the configured limits");

endmodule

### tb/servo_map_checker.sv
`timescale 1ns / 100ps

module servo_map_checker (
	input  logic clk,
	input  logic arst_n,
	emap_in_if   samples,
	emap_out_if  results,
	emap_cfg_if  cfg,
	output int   errors,
	output int   pending
);

	logic [emap_pkg::SAMPLE_W-1:0] win_low;
	logic [emap_pkg::SAMPLE_W-1:0] win_high;
	logic [emap_pkg::PULSE_W-1:0]  pulse_min;
	logic [emap_pkg::PULSE_W-1:0]  pulse_max;
	logic [emap_pkg::SAMPLE_W-1:0] level_avg [emap_pkg::JOINTS_DEF];
	emap_pkg::emap_res_t           servo_results_q [$];
	emap_pkg::emap_res_t           want;

	// Clamp into [lo, hi] and map onto [out_lo, out_hi]; an empty window gives out_lo.
	function automatic longint span_map(input longint v, input longint lo, input longint hi,
		input longint out_lo, input longint out_hi);
		longint q;
		if (hi <= lo)
			return out_lo;
		if (v < lo)
			v = lo;
		if (v > hi)
			v = hi;
		q = (v - lo) * (out_hi - out_lo) / (hi - lo) + out_lo;
		if (q < 0)
			q = 0;
		return q;
	endfunction

	function automatic emap_pkg::emap_res_t predict_servo_result(
		input logic [emap_pkg::CH_W-1:0] joint,
		input logic [emap_pkg::SAMPLE_W-1:0] sample);
		emap_pkg::emap_res_t r;
		int unsigned         slot;
		longint              pulse;
		longint              angle;
		slot = joint % emap_pkg::JOINTS_DEF;
		level_avg[slot] = emap_pkg::SAMPLE_W'((level_avg[slot]
			* ((1 << emap_pkg::SMOOTH_SHIFT_DEF) - 1) + sample) >> emap_pkg::SMOOTH_SHIFT_DEF);
		pulse = span_map(level_avg[slot], win_low, win_high, pulse_max, pulse_min);
		angle = span_map(pulse, pulse_min, pulse_max, 0, emap_pkg::ANGLE_FULL);
		if (angle > emap_pkg::ANGLE_FULL)
			angle = emap_pkg::ANGLE_FULL;
		r.joint = joint;
		r.level = level_avg[slot];
		r.pulse = emap_pkg::PULSE_W'(pulse);
		r.angle = emap_pkg::ANGLE_W'(angle);
		return r;
	endfunction

	task automatic check_field(input string name, input int unsigned exp_val,
		input int unsigned act_val);
		if (exp_val != act_val) begin
			$error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_low = emap_pkg::WIN_LOW_RST;
			win_high = emap_pkg::WIN_HIGH_RST;
			pulse_min = emap_pkg::PULSE_MIN_RST;
			pulse_max = emap_pkg::PULSE_MAX_RST;
			for (int j = 0; j < emap_pkg::JOINTS_DEF; j++)
				level_avg[j] = '0;
			servo_results_q.delete();
			errors = 0;
			pending <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					emap_pkg::REG_WIN_LOW:   win_low = cfg.data[emap_pkg::SAMPLE_W-1:0];
					emap_pkg::REG_WIN_HIGH:  win_high = cfg.data[emap_pkg::SAMPLE_W-1:0];
					emap_pkg::REG_PULSE_MIN: pulse_min = cfg.data[emap_pkg::PULSE_W-1:0];
					emap_pkg::REG_PULSE_MAX: pulse_max = cfg.data[emap_pkg::PULSE_W-1:0];
					default: ;
				endcase
			end
			if (results.valid && results.ready) begin
				if (servo_results_q.size() == 0) begin
					$error("Result for joint %0d arrived with nothing outstanding",
						results.joint_out);
					errors++;
				end else begin
					want = servo_results_q.pop_front();
					check_field("joint_out", want.joint, results.joint_out);
					check_field("smoothed_level", want.level, results.smoothed_level);
					check_field("pulse_width_us", want.pulse, results.pulse_width_us);
					check_field("angle_degrees", want.angle, results.angle_degrees);
				end
			end
			if (samples.valid && samples.ready)
				servo_results_q.push_back(predict_servo_result(samples.joint_channel,
					samples.adc_sample));
			pending <= servo_results_q.size();
		end
	end

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	bit                  idle_en = 1'b1;
	int                  stall_left = 0;
	int                  errors;
	int                  pending;
	int                  sent = 0;
	int                  settings = 1;
	int                  target_level [emap_pkg::JOINTS_DEF];

	emap_in_if  samples_if();
	emap_out_if results_if();
	emap_cfg_if cfg_if();

	ema_to_servo_pulse_mapper uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples_if),
		.results (results_if),
		.cfg     (cfg_if)
	);

	servo_map_checker servo_check (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples_if),
		.results (results_if),
		.cfg     (cfg_if),
		.errors  (errors),
		.pending (pending)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			results_if.ready <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
		end else if (idle_en && $urandom_range(0, 5) == 0) begin
			results_if.ready <= 1'b0;
			stall_left <= $urandom_range(0, 3);
		end else begin
			results_if.ready <= 1'b1;
		end
	end

	task automatic send_sample(input logic [emap_pkg::CH_W-1:0] joint,
		input logic [emap_pkg::SAMPLE_W-1:0] level);
		if (idle_en && $urandom_range(0, 3) == 0) begin
			samples_if.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		samples_if.valid <= 1'b1;
		samples_if.joint_channel <= joint;
		samples_if.adc_sample <= level;
		@(posedge clk);
		while (!samples_if.ready)
			@(posedge clk);
		sent++;
	endtask

	task automatic drain();
		samples_if.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input emap_pkg::emap_reg_e_t idx,
		input logic [emap_pkg::CFG_DATA_W-1:0] value);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= value;
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
	endtask

	task automatic set_regs(input logic [emap_pkg::CFG_DATA_W-1:0] lo,
		input logic [emap_pkg::CFG_DATA_W-1:0] hi,
		input logic [emap_pkg::CFG_DATA_W-1:0] pmin,
		input logic [emap_pkg::CFG_DATA_W-1:0] pmax);
		write_reg(emap_pkg::REG_WIN_LOW, lo);
		write_reg(emap_pkg::REG_WIN_HIGH, hi);
		write_reg(emap_pkg::REG_PULSE_MIN, pmin);
		write_reg(emap_pkg::REG_PULSE_MAX, pmax);
		cfg_if.valid <= 1'b0;
		settings++;
	endtask

	task automatic set_random_regs();
		int lo;
		int hi;
		int pmin;
		int pmax;
		int swap;
		lo = $urandom_range(0, 4095);
		hi = $urandom_range(0, 4095);
		if (lo > hi) begin
			swap = lo;
			lo = hi;
			hi = swap;
		end
		if ($urandom_range(0, 7) == 0)
			hi = $urandom_range(0, lo);
		pmin = $urandom_range(0, 19999);
		pmax = $urandom_range(0, 19999);
		if ($urandom_range(0, 7) == 0)
			pmax = $urandom_range(0, 32767);
		if (pmin > pmax && $urandom_range(0, 7) != 0) begin
			swap = pmin;
			pmin = pmax;
			pmax = swap;
		end
		set_regs({3'($urandom_range(0, 7)), 12'(lo)}, {3'($urandom_range(0, 7)), 12'(hi)},
			15'(pmin), 15'(pmax));
	endtask

	task automatic send_random_sample();
		int joint;
		int level;
		joint = $urandom_range(0, emap_pkg::JOINTS_DEF - 1);
		if ($urandom_range(0, 23) == 0) begin
			case ($urandom_range(0, 3))
				0: target_level[joint] = 0;
				1: target_level[joint] = 4095;
				default: target_level[joint] = $urandom_range(0, 4095);
			endcase
		end
		if ($urandom_range(0, 3) == 0) begin
			level = $urandom_range(0, 4095);
		end else begin
			level = target_level[joint] + $urandom_range(0, 64) - 32;
			if (level < 0)
				level = 0;
			if (level > 4095)
				level = 4095;
		end
		send_sample(emap_pkg::CH_W'(joint), emap_pkg::SAMPLE_W'(level));
	endtask

	initial begin
		samples_if.valid <= 1'b0;
		samples_if.joint_channel <= '0;
		samples_if.adc_sample <= '0;
		cfg_if.valid <= 1'b0;
		cfg_if.index <= emap_pkg::REG_WIN_LOW;
		cfg_if.data <= '0;
		for (int j = 0; j < emap_pkg::JOINTS_DEF; j++)
			target_level[j] = $urandom_range(0, 4095);
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_sample(2'd0, 12'd4095);
		send_sample(2'd1, 12'd0);
		send_sample(2'd2, 12'haaa);
		send_sample(2'd3, 12'h555);
		send_sample(2'd0, 12'd4095);
		send_sample(2'd0, 12'd4095);
		send_sample(2'd0, 12'd4095);
		drain();

		set_regs(15'd0, 15'd4095, 15'd0, 15'd32767);
		send_sample(2'd0, 12'd4095);
		send_sample(2'd0, 12'd4095);
		send_sample(2'd3, 12'd0);
		send_sample(2'd2, 12'd4095);
		drain();

		// Empty converter window and empty pulse window, first equal then reversed.
		set_regs(15'd3000, 15'd3000, 15'd2000, 15'd2000);
		send_sample(2'd1, 12'd3000);
		send_sample(2'd2, 12'd100);
		drain();
		set_regs(15'h7fff, 15'd0, 15'd32767, 15'd0);
		send_sample(2'd0, 12'd4095);
		send_sample(2'd3, 12'd0);
		drain();

		set_regs(15'd100, 15'd101, 15'd0, 15'd19999);
		send_sample(2'd1, 12'd4095);
		send_sample(2'd1, 12'd812);
		send_sample(2'd2, 12'd0);
		drain();

		for (int phase = 0; phase < 8; phase++) begin
			idle_en = (phase != 3) && (phase != 7);
			case (phase)
				0: set_regs(15'd0, 15'd4095, 15'd0, 15'd32767);
				1: set_regs(15'd4095, 15'd0, 15'd19999, 15'd0);
				2: set_regs(15'd600, 15'd3500, 15'd650, 15'd2350);
				default: set_random_regs();
			endcase
			for (int n = 0; n < 125; n++)
				send_random_sample();
			drain();
		end

		repeat (40) @(posedge clk);
		$display("Sent %0d samples to four joints under %0d register settings.", sent, settings);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#2000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
